FILE: src/tsbg_pkg.sv
// ----------------------------------------------------------------------------
// tsbg_pkg: shared types and constants for the turn signal brake gate
// Payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package tsbg_pkg;

  localparam int TICK_BITS_DEFAULT = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TURN_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_GAP   = 1'd1;

  localparam logic [CFG_W-1:0] TURN_WINDOW_RESET = 16'd80;
  localparam logic [CFG_W-1:0] BRAKE_GAP_RESET   = 16'd5;

  typedef struct packed {
    logic tick;
    logic left_turn_level;
    logic right_turn_level;
    logic brake_level;
  } in_item_t;

  typedef struct packed {
    logic left_suppress;
    logic right_suppress;
  } out_item_t;

endpackage

FILE: src/turn_signal_brake_gate_top.sv
// ----------------------------------------------------------------------------
// turn_signal_brake_gate_top: turn lamp gating against brake lamp
// Tracks falling edges of the turn and brake lines on a tick counter and
// flags a turn output for suppression while braking.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one item per cycle; the result register drains while the next
//   item is taken, so a stall on the output only blocks when it is full.
// Reset (rst, synchronous): tick count, fall times and line history clear to
//   zero, window and gap registers load 80 and 5, no result pending.
module turn_signal_brake_gate_top #(
  parameter int TICK_BITS = tsbg_pkg::TICK_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tsbg_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tsbg_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [tsbg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsbg_pkg::CFG_W-1:0]           cfg_data
);
  import tsbg_pkg::*;

  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

  logic [CFG_W-1:0]     turn_window;
  logic [CFG_W-1:0]     brake_gap;
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] tick_count_inc;
  logic [TICK_BITS-1:0] left_fall;
  logic [TICK_BITS-1:0] right_fall;
  logic [TICK_BITS-1:0] brake_fall;
  logic [2:0]           prev_levels;

  logic [TICK_BITS-1:0] tick_count_next;
  logic                 accept;
  logic                 left_ok;
  logic                 right_ok;
  logic                 left_fell;
  logic                 right_fell;
  logic                 brake_fell;

  // Side allowed while braking: edge younger than window and far enough
  // from the brake edge (the gap is compared with the magnitude of the signed difference).
  function automatic logic side_ok(input logic [TICK_BITS-1:0] fall,
                                   input logic [TICK_BITS-1:0] now,
                                   input logic [TICK_BITS-1:0] bfall,
                                   input logic [CFG_W-1:0]     window,
                                   input logic [CFG_W-1:0]     gap);
    logic [TICK_BITS-1:0] age;
    logic [TICK_BITS-1:0] diff;
    logic [TICK_BITS-1:0] span;
    logic                 young;
    logic                 apart;
    age   = now - fall;
    diff  = fall - bfall;
    span  = diff[TICK_BITS-1] ? (~diff + TICK_BITS'(1)) : diff;
    young = CMP_W'(age) < CMP_W'(window);
    apart = CMP_W'(span) > CMP_W'(gap);
    return young && apart;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign tick_count_inc  = tick_count + TICK_BITS'(1);
  assign tick_count_next = in_data.tick ? tick_count_inc : tick_count;

  always_comb begin
    left_ok  = !in_data.brake_level ||
               side_ok(left_fall, tick_count_next, brake_fall, turn_window, brake_gap);
    right_ok = !in_data.brake_level ||
               side_ok(right_fall, tick_count_next, brake_fall, turn_window, brake_gap);
    left_fell  = prev_levels[0] && !in_data.left_turn_level;
    right_fell = prev_levels[1] && !in_data.right_turn_level;
    brake_fell = prev_levels[2] && !in_data.brake_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_window <= TURN_WINDOW_RESET;
      brake_gap   <= BRAKE_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TURN_WINDOW: turn_window <= cfg_data;
        REG_BRAKE_GAP:   brake_gap   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      left_fall   <= '0;
      right_fall  <= '0;
      brake_fall  <= '0;
      prev_levels <= '0;
    end else if (accept) begin
      tick_count <= tick_count_next;
      if (left_fell)  left_fall  <= tick_count_next;
      if (right_fell) right_fall <= tick_count_next;
      if (brake_fell) brake_fall <= tick_count_next;
      prev_levels <= {in_data.brake_level, in_data.right_turn_level,
                      in_data.left_turn_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.left_suppress  <= !left_ok;
      out_data.right_suppress <= !right_ok;
    end
  end

`ifndef SYNTHESIS
  // no brake on the transfer means nothing is suppressed
  a_no_brake_pass: assert property (@(posedge clk) disable iff (rst)
    accept && !in_data.brake_level |=> out_data == '0)
    else $error("suppress set without brake");

  // zero window blocks both turns while braking
  a_zero_window: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.brake_level && turn_window == '0 |=>
      out_data.left_suppress && out_data.right_suppress)
    else $error("turn allowed with zero window");

  // tick count moves by at most one per cycle
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> tick_count == $past(tick_count) ||
             tick_count == $past(tick_count) + TICK_BITS'(1))
    else $error("tick count jumped");

  // a brake fall stamps the brake fall time with the updated tick count
  a_fall_stamp: assert property (@(posedge clk) disable iff (rst)
    accept && brake_fell |=> brake_fall == tick_count)
    else $error("brake fall time not stamped");

  // line history and tick count are frozen without a transfer
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(prev_levels) && $stable(tick_count))
    else $error("state changed without transfer");
`endif

endmodule
